### rtl/core/gh94_pkg.sv
// Shared types, constants and functions of the GOST 94 hash engine.
`default_nettype none
package gh94_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] block_t;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd10, 4'd4, 4'd5, 4'd6, 4'd8, 4'd1, 4'd3, 4'd7,
		  4'd13, 4'd12, 4'd14, 4'd0, 4'd9, 4'd2, 4'd11, 4'd15},
		'{4'd5, 4'd15, 4'd4, 4'd0, 4'd2, 4'd13, 4'd11, 4'd9,
		  4'd1, 4'd7, 4'd6, 4'd3, 4'd12, 4'd14, 4'd10, 4'd8},
		'{4'd7, 4'd15, 4'd12, 4'd14, 4'd9, 4'd4, 4'd1, 4'd0,
		  4'd3, 4'd11, 4'd5, 4'd2, 4'd6, 4'd10, 4'd8, 4'd13},
		'{4'd4, 4'd10, 4'd7, 4'd12, 4'd0, 4'd15, 4'd2, 4'd8,
		  4'd14, 4'd1, 4'd6, 4'd5, 4'd13, 4'd11, 4'd9, 4'd3},
		'{4'd7, 4'd6, 4'd4, 4'd11, 4'd9, 4'd12, 4'd2, 4'd10,
		  4'd1, 4'd8, 4'd0, 4'd14, 4'd15, 4'd13, 4'd3, 4'd5},
		'{4'd7, 4'd6, 4'd2, 4'd4, 4'd13, 4'd9, 4'd15, 4'd0,
		  4'd10, 4'd1, 4'd5, 4'd11, 4'd8, 4'd14, 4'd12, 4'd3},
		'{4'd13, 4'd14, 4'd4, 4'd1, 4'd7, 4'd0, 4'd5, 4'd10,
		  4'd3, 4'd12, 4'd8, 4'd15, 4'd6, 4'd2, 4'd9, 4'd11},
		'{4'd1, 4'd3, 4'd10, 4'd9, 4'd5, 4'd11, 4'd4, 4'd15,
		  4'd8, 4'd6, 4'd7, 4'd14, 4'd13, 4'd0, 4'd2, 4'd12}
	};

	localparam block_t KEY_CONST = '{
		32'hff00ffff, 32'h000000ff, 32'hff0000ff, 32'h00ffff00,
		32'h00ff00ff, 32'h00ff00ff, 32'hff00ff00, 32'hff00ff00
	};

	localparam logic [63:0] BLOCK_BITS = 64'd256;

	function automatic word_t round_f(input word_t x);
		word_t y;
		for (int n = 0; n < 8; n++) begin
			y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
		end
		return {y[20:0], y[31:21]};
	endfunction

	function automatic block_t key_gen(input block_t w);
		block_t k;
		for (int j = 0; j < 2; j++) begin
			for (int b = 0; b < 4; b++) begin
				for (int c = 0; c < 4; c++) begin
					k[4*j + b][8*c +: 8] = w[2*c + j][8*b +: 8];
				end
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/core/gh94_if.sv
// Valid/ready channel interfaces for message input and digest output.
`default_nettype none
interface gh94_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface gh94_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;
	modport source (output valid, digest_word, last_word, input ready);
	modport sink (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

### rtl/core/gh94_compress.sv
// Iterative compression unit: key generation, one cipher round per cycle, psi mixing.
`default_nettype none
module gh94_compress (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  gh94_pkg::block_t h_in,
	input  gh94_pkg::block_t m_in,
	output logic             done,
	output gh94_pkg::block_t h_out
);
	import gh94_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_KEY, S_ROUND, S_X, S_Y, S_H} state_t;

	state_t     state_q;
	block_t     h_q, m_q, u_q, v_q, key_q, s_q, x_q, y_q;
	word_t      a_q, b_q;
	logic [4:0] rnd_q;
	logic [1:0] pair_q;

	logic [2:0] idx;
	word_t      fval;
	block_t     u_nx, v_nx, x_c, y_c, h_c;

	function automatic word_t sl(input word_t w);
		return {w[15:0], 16'h0000};
	endfunction
	function automatic word_t sr(input word_t w);
		return {16'h0000, w[31:16]};
	endfunction
	function automatic word_t lo(input word_t w);
		return {16'h0000, w[15:0]};
	endfunction
	function automatic word_t hi(input word_t w);
		return {w[31:16], 16'h0000};
	endfunction

	assign idx  = (rnd_q < 5'd24) ? rnd_q[2:0] : ~rnd_q[2:0];
	assign fval = round_f(key_q[idx] + (rnd_q[0] ? b_q : a_q));

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			u_nx[j] = u_q[j+2];
		end
		u_nx[6] = u_q[0] ^ u_q[2];
		u_nx[7] = u_q[1] ^ u_q[3];
		if (pair_q == 2'd1) begin
			u_nx = u_nx ^ KEY_CONST;
		end
		v_nx[0] = v_q[4];
		v_nx[2] = v_q[6];
		v_nx[4] = v_q[0] ^ v_q[2];
		v_nx[6] = v_q[4] ^ v_q[2];
		v_nx[1] = v_q[5];
		v_nx[3] = v_q[7];
		v_nx[5] = v_q[1] ^ v_q[3];
		v_nx[7] = v_q[5] ^ v_q[3];
	end

	always_comb begin
		x_c[0] = m_q[0] ^ s_q[6];
		x_c[1] = m_q[1] ^ s_q[7];
		x_c[2] = m_q[2] ^ sl(s_q[0]) ^ sr(s_q[0]) ^ lo(s_q[0]) ^ lo(s_q[1]) ^ sr(s_q[1])
			^ sl(s_q[2]) ^ s_q[6] ^ sl(s_q[6]) ^ hi(s_q[7]) ^ sr(s_q[7]);
		x_c[3] = m_q[3] ^ lo(s_q[0]) ^ sl(s_q[0]) ^ lo(s_q[1]) ^ sl(s_q[1]) ^ sr(s_q[1])
			^ sl(s_q[2]) ^ sr(s_q[2]) ^ sl(s_q[3]) ^ s_q[6] ^ sl(s_q[6]) ^ sr(s_q[6])
			^ lo(s_q[7]) ^ sl(s_q[7]) ^ sr(s_q[7]);
		x_c[4] = m_q[4] ^ hi(s_q[0]) ^ sl(s_q[0]) ^ sr(s_q[0]) ^ hi(s_q[1]) ^ sr(s_q[1])
			^ sl(s_q[2]) ^ sr(s_q[2]) ^ sl(s_q[3]) ^ sr(s_q[3]) ^ sl(s_q[4]) ^ sl(s_q[6])
			^ sr(s_q[6]) ^ lo(s_q[7]) ^ sl(s_q[7]) ^ sr(s_q[7]);
		x_c[5] = m_q[5] ^ sl(s_q[0]) ^ sr(s_q[0]) ^ hi(s_q[0]) ^ lo(s_q[1]) ^ s_q[2]
			^ sr(s_q[2]) ^ sl(s_q[3]) ^ sr(s_q[3]) ^ sl(s_q[4]) ^ sr(s_q[4]) ^ sl(s_q[5])
			^ sl(s_q[6]) ^ sr(s_q[6]) ^ hi(s_q[7]) ^ sl(s_q[7]) ^ sr(s_q[7]);
		x_c[6] = m_q[6] ^ s_q[0] ^ sr(s_q[1]) ^ sl(s_q[2]) ^ s_q[3] ^ sr(s_q[3])
			^ sl(s_q[4]) ^ sr(s_q[4]) ^ sl(s_q[5]) ^ sr(s_q[5]) ^ s_q[6] ^ sl(s_q[6])
			^ sr(s_q[6]) ^ sl(s_q[7]);
		x_c[7] = m_q[7] ^ hi(s_q[0]) ^ sl(s_q[0]) ^ lo(s_q[1]) ^ sl(s_q[1]) ^ sr(s_q[2])
			^ sl(s_q[3]) ^ s_q[4] ^ sr(s_q[4]) ^ sl(s_q[5]) ^ sr(s_q[5]) ^ sr(s_q[6])
			^ lo(s_q[7]) ^ sl(s_q[7]) ^ sr(s_q[7]);
	end

	always_comb begin
		for (int j = 0; j < 7; j++) begin
			y_c[j] = h_q[j] ^ sl(x_q[j+1]) ^ sr(x_q[j]);
		end
		y_c[7] = h_q[7] ^ hi(x_q[0]) ^ sl(x_q[0]) ^ sr(x_q[7]) ^ hi(x_q[1]) ^ sl(x_q[1])
			^ sl(x_q[6]) ^ hi(x_q[7]);
	end

	always_comb begin
		h_c[0] = hi(y_q[0]) ^ sl(y_q[0]) ^ sr(y_q[0]) ^ sr(y_q[1]) ^ hi(y_q[1]) ^ sl(y_q[2])
			^ sr(y_q[3]) ^ sl(y_q[4]) ^ sr(y_q[5]) ^ y_q[5] ^ sr(y_q[6]) ^ sl(y_q[7])
			^ sr(y_q[7]) ^ lo(y_q[7]);
		h_c[1] = sl(y_q[0]) ^ sr(y_q[0]) ^ hi(y_q[0]) ^ lo(y_q[1]) ^ y_q[2] ^ sr(y_q[2])
			^ sl(y_q[3]) ^ sr(y_q[4]) ^ sl(y_q[5]) ^ sl(y_q[6]) ^ y_q[6] ^ hi(y_q[7])
			^ sr(y_q[7]);
		h_c[2] = lo(y_q[0]) ^ sl(y_q[0]) ^ sl(y_q[1]) ^ sr(y_q[1]) ^ hi(y_q[1]) ^ sl(y_q[2])
			^ sr(y_q[3]) ^ y_q[3] ^ sl(y_q[4]) ^ sr(y_q[5]) ^ y_q[6] ^ sr(y_q[6])
			^ lo(y_q[7]) ^ sl(y_q[7]) ^ sr(y_q[7]);
		h_c[3] = sl(y_q[0]) ^ sr(y_q[0]) ^ hi(y_q[0]) ^ hi(y_q[1]) ^ sr(y_q[1]) ^ sl(y_q[2])
			^ sr(y_q[2]) ^ y_q[2] ^ sl(y_q[3]) ^ sr(y_q[4]) ^ y_q[4] ^ sl(y_q[5])
			^ sl(y_q[6]) ^ lo(y_q[7]) ^ sr(y_q[7]);
		h_c[4] = sr(y_q[0]) ^ sl(y_q[1]) ^ y_q[1] ^ sr(y_q[2]) ^ y_q[2] ^ sl(y_q[3])
			^ sr(y_q[3]) ^ y_q[3] ^ sl(y_q[4]) ^ sr(y_q[5]) ^ y_q[5] ^ sl(y_q[6])
			^ sr(y_q[6]) ^ sl(y_q[7]);
		h_c[5] = sl(y_q[0]) ^ hi(y_q[0]) ^ sl(y_q[1]) ^ sr(y_q[1]) ^ hi(y_q[1]) ^ sl(y_q[2])
			^ y_q[2] ^ sr(y_q[3]) ^ y_q[3] ^ sl(y_q[4]) ^ sr(y_q[4]) ^ y_q[4] ^ sl(y_q[5])
			^ sl(y_q[6]) ^ sr(y_q[6]) ^ y_q[6] ^ sl(y_q[7]) ^ sr(y_q[7]) ^ hi(y_q[7]);
		h_c[6] = y_q[0] ^ y_q[2] ^ sr(y_q[2]) ^ y_q[3] ^ sl(y_q[3]) ^ y_q[4] ^ sr(y_q[4])
			^ sl(y_q[5]) ^ sr(y_q[5]) ^ y_q[5] ^ sl(y_q[6]) ^ sr(y_q[6]) ^ y_q[6]
			^ sl(y_q[7]) ^ y_q[7];
		h_c[7] = y_q[0] ^ sr(y_q[0]) ^ sl(y_q[1]) ^ sr(y_q[1]) ^ sl(y_q[2]) ^ sr(y_q[3])
			^ y_q[3] ^ sl(y_q[4]) ^ y_q[4] ^ sr(y_q[5]) ^ y_q[5] ^ sl(y_q[6]) ^ sr(y_q[6])
			^ sl(y_q[7]) ^ y_q[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			rnd_q   <= '0;
			pair_q  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						h_q     <= h_in;
						m_q     <= m_in;
						u_q     <= h_in;
						v_q     <= m_in;
						pair_q  <= '0;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					key_q   <= key_gen(u_q ^ v_q);
					a_q     <= h_q[{pair_q, 1'b0}];
					b_q     <= h_q[{pair_q, 1'b1}];
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (rnd_q[0]) begin
						a_q <= a_q ^ fval;
					end else begin
						b_q <= b_q ^ fval;
					end
					rnd_q <= rnd_q + 5'd1;
					if (rnd_q == 5'd31) begin
						s_q[{pair_q, 1'b0}] <= b_q;
						s_q[{pair_q, 1'b1}] <= a_q ^ fval;
						if (pair_q == 2'd3) begin
							state_q <= S_X;
						end else begin
							u_q     <= u_nx;
							v_q     <= v_nx;
							pair_q  <= pair_q + 2'd1;
							state_q <= S_KEY;
						end
					end
				end
				S_X: begin
					x_q     <= x_c;
					state_q <= S_Y;
				end
				S_Y: begin
					y_q     <= y_c;
					state_q <= S_H;
				end
				S_H: begin
					h_out   <= h_c;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/gost_94_hash_engine.sv
// Top level of the GOST R 34.11-94 hash engine.
// One message byte per transaction; a byte that does not complete a 32-byte block is only
// stored in the buffer. The byte that completes a block is accepted, added word-serially
// to the checksum and starts one compression (for each of the four word pairs a key
// generation and 32 cipher rounds, then psi mixing); the new chain value is then taken, all on
// the single cipher round unit. A finish transaction runs up to three compressions (padded
// block, length, checksum: two without a partial block), then presents eight digest words,
// word 0 first, and returns to the empty state. Input is not ready meanwhile.
`default_nettype none
module gost_94_hash_engine (
	input wire         clk,
	input wire         arst_n,
	gh94_in_if.sink    msg,
	gh94_out_if.source dig
);
	import gh94_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_SUM, ST_GO, ST_WAIT, ST_OUT} state_t;
	typedef enum logic [1:0] {PH_DATA, PH_LAST, PH_LEN, PH_CSUM} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [7:0]  buf_q [32];
	logic [4:0]  fill_q;
	logic [2:0]  wcnt_q;
	logic        carry_q;
	logic [63:0] bitlen_q;
	block_t      chain_q, csum_q;

	block_t      blk, msg_sel, h_new;
	logic        cmp_start, cmp_done;
	logic [32:0] sum;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			blk[i] = {buf_q[4*i+3], buf_q[4*i+2], buf_q[4*i+1], buf_q[4*i]};
		end
	end

	always_comb begin
		case (phase_q)
			PH_LEN:  msg_sel = {192'd0, bitlen_q};
			PH_CSUM: msg_sel = csum_q;
			default: msg_sel = blk;
		endcase
	end

	assign sum       = {1'b0, csum_q[wcnt_q]} + {1'b0, blk[wcnt_q]} + {32'd0, carry_q};
	assign cmp_start = (state_q == ST_GO);

	assign msg.ready       = (state_q == ST_IDLE);
	assign dig.valid       = (state_q == ST_OUT);
	assign dig.digest_word = chain_q[wcnt_q];
	assign dig.last_word   = (wcnt_q == 3'd7);

	gh94_compress u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.h_in   (chain_q),
		.m_in   (msg_sel),
		.done   (cmp_done),
		.h_out  (h_new)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && msg.valid && !msg.action) begin
			buf_q[fill_q] <= msg.data_byte;
		end else if (state_q == ST_PAD) begin
			for (int b = 0; b < 32; b++) begin
				if (5'(b) >= fill_q) begin
					buf_q[b] <= 8'h00;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_DATA;
			fill_q   <= '0;
			wcnt_q   <= '0;
			carry_q  <= 1'b0;
			bitlen_q <= '0;
			chain_q  <= '0;
			csum_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg.valid) begin
						wcnt_q  <= '0;
						carry_q <= 1'b0;
						if (!msg.action) begin
							fill_q <= fill_q + 5'd1;
							if (fill_q == 5'd31) begin
								bitlen_q <= bitlen_q + BLOCK_BITS;
								phase_q  <= PH_DATA;
								state_q  <= ST_SUM;
							end
						end else if (fill_q != 5'd0) begin
							state_q <= ST_PAD;
						end else begin
							phase_q <= PH_LEN;
							state_q <= ST_GO;
						end
					end
				end
				ST_PAD: begin
					bitlen_q <= bitlen_q + {56'd0, fill_q, 3'b000};
					fill_q   <= '0;
					phase_q  <= PH_LAST;
					state_q  <= ST_SUM;
				end
				ST_SUM: begin
					csum_q[wcnt_q] <= sum[31:0];
					carry_q        <= sum[32];
					wcnt_q         <= wcnt_q + 3'd1;
					if (wcnt_q == 3'd7) begin
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (cmp_done) begin
						chain_q <= h_new;
						case (phase_q)
							PH_DATA: state_q <= ST_IDLE;
							PH_LAST: begin
								phase_q <= PH_LEN;
								state_q <= ST_GO;
							end
							PH_LEN: begin
								phase_q <= PH_CSUM;
								state_q <= ST_GO;
							end
							default: begin
								wcnt_q  <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (dig.ready) begin
						wcnt_q <= wcnt_q + 3'd1;
						if (wcnt_q == 3'd7) begin
							chain_q  <= '0;
							csum_q   <= '0;
							bitlen_q <= '0;
							phase_q  <= PH_DATA;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/gh94_checker.sv
// Port-level checks of the hash engine and their binding to the top level.
`default_nettype none
module gh94_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        in_action,
	input wire        out_valid,
	input wire        out_ready,
	input wire        out_last,
	input wire [31:0] out_word
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while digest pending");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action |=> !in_ready && !out_valid)
		else $error("finish transaction not processed");

	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid && in_ready)
		else $error("digest did not end after last word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("stalled digest word changed");
endmodule

bind gost_94_hash_engine gh94_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_action (msg.action),
	.out_valid (dig.valid),
	.out_ready (dig.ready),
	.out_last  (dig.last_word),
	.out_word  (dig.digest_word)
);
`default_nettype wire
